[rtl/core/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// shared constants, codes and types of the linear double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;
  localparam int CAP_W = 7;
  localparam int CMD_W = 3;
  localparam int ST_W  = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  // commands
  localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISPLAY   = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_DONE       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL       = 3'd1;
  localparam logic [ST_W-1:0] ST_FRONT_REF  = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY      = 3'd3;
  localparam logic [ST_W-1:0] ST_DISP_ELEM  = 3'd4;
  localparam logic [ST_W-1:0] ST_DISP_EMPTY = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_DISP = 3'b100
  } state_e;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic signed [DW-1:0] element;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [DW-1:0] wdata;
    logic                 re;
    logic [AW-1:0]        raddr;
  } mem_req_t;

endpackage

[rtl/core/deq_mem.sv]
// ----------------------------------------------------------------------------
// deq_mem
// slot storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module deq_mem
  import deq_pkg::*;
(
  input  logic                 clk_i,
  input  mem_req_t             req_i,
  output logic signed [DW-1:0] rdata_o
);

  logic signed [DW-1:0] mem [DEPTH];
  logic signed [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// command decode, front and rear indices, display walk
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic signed [DW-1:0] value_i,
  output logic                 in_stall_o,
  input  logic [CAP_W-1:0]     cap_i,
  input  logic                 out_free_i,
  output logic                 res_valid_o,
  output res_t                 res_o,
  output mem_req_t             mem_req_o,
  input  logic signed [DW-1:0] mem_rdata_i
);

  state_e        state_q, state_d;
  logic [IW-1:0] front_q, front_d;
  logic [IW-1:0] rear_q, rear_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [IW-1:0] eff_cap;
  logic [IW-1:0] front_dec, rear_dec;
  logic          empty;
  logic          accept;
  logic          disp_last;

  // capacity zero acts as one, above depth acts as depth
  always_comb begin
    if (cap_i == '0) begin
      eff_cap = IW'(1);
    end else if (cap_i > CAP_W'(DEPTH)) begin
      eff_cap = IW'(DEPTH);
    end else begin
      eff_cap = IW'(cap_i);
    end
  end

  assign empty     = front_q >= rear_q;
  assign front_dec = front_q - 1'b1;
  assign rear_dec  = rear_q - 1'b1;
  assign disp_last = ptr_q == rear_q;

  assign in_stall_o = !((state_q == S_IDLE) && out_free_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    ptr_d       = ptr_q;
    mem_req_o   = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_INS_REAR: begin
              res_valid_o = 1'b1;
              res_o.last  = 1'b1;
              if (rear_q >= eff_cap) begin
                res_o.status = ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = rear_q[AW-1:0];
                mem_req_o.wdata = value_i;
                rear_d          = rear_q + 1'b1;
                res_o.status    = ST_DONE;
              end
            end
            CMD_INS_FRONT: begin
              res_valid_o = 1'b1;
              res_o.last  = 1'b1;
              if (front_q == '0) begin
                res_o.status = ST_FRONT_REF;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = front_dec[AW-1:0];
                mem_req_o.wdata = value_i;
                front_d         = front_dec;
                res_o.status    = ST_DONE;
              end
            end
            CMD_DEL_FRONT, CMD_DEL_REAR: begin
              if (empty) begin
                res_valid_o  = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = ST_EMPTY;
                front_d      = '0;
                rear_d       = '0;
              end else if (command_i == CMD_DEL_FRONT) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = front_q[AW-1:0];
                front_d         = front_q + 1'b1;
                state_d         = S_RD;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = rear_dec[AW-1:0];
                rear_d          = rear_dec;
                state_d         = S_RD;
              end
            end
            CMD_DISPLAY: begin
              if (empty) begin
                res_valid_o  = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = ST_DISP_EMPTY;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = front_q[AW-1:0];
                ptr_d           = front_q + 1'b1;
                state_d         = S_DISP;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (out_free_i) begin
          res_valid_o   = 1'b1;
          res_o.status  = ST_DONE;
          res_o.element = mem_rdata_i;
          res_o.last    = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_DISP: begin
        if (out_free_i) begin
          res_valid_o   = 1'b1;
          res_o.status  = ST_DISP_ELEM;
          res_o.element = mem_rdata_i;
          res_o.last    = disp_last;
          if (disp_last) begin
            state_d = S_IDLE;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = ptr_q[AW-1:0];
            ptr_d           = ptr_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      rear_q  <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      ptr_q   <= ptr_d;
    end
  end

endmodule

[rtl/core/deq_outreg.sv]
// ----------------------------------------------------------------------------
// deq_outreg
// output register between the controller and the result channel
// ----------------------------------------------------------------------------
module deq_outreg
  import deq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  input  res_t res_i,
  output logic out_free_o,
  input  logic out_stall_i,
  output logic out_valid_o,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  // slot frees when empty or being taken this cycle
  assign out_free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[rtl/core/double_ended_queue_linear_top.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_linear_top
// linear-array double-ended queue with a fixed slot memory and capacity register
// ----------------------------------------------------------------------------
// results: inserts, refusals and empty results appear in the cycle after the item
//   is taken; deletes go through the registered slot memory read and output register
// input: 1 item per cycle for inserts unless the output stalls; a delete holds input
//   until its element is passed on, display until its last element is, with one read
//   per cycle while the output is free on the single read port of the slot memory
// reset: indices cleared, capacity 64, slot contents left as they are
module double_ended_queue_linear_top
  import deq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // item input
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic signed [DW-1:0]    value_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ST_W-1:0]         status_o,
  output logic signed [DW-1:0]    element_o,
  output logic                    last_o,
  // capacity register write
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CAP_W-1:0]        cfg_capacity_i
);

  logic [CAP_W-1:0]     cap_q;
  logic                 out_free;
  logic                 res_valid;
  res_t                 res_ctrl;
  res_t                 res_out;
  mem_req_t             mem_req;
  logic signed [DW-1:0] mem_rdata;

  // capacity register; write it only while the queue is quiet, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_capacity_i;
    end
  end

  // command decode and index bookkeeping
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .value_i     (value_i),
    .in_stall_o  (in_stall_o),
    .cap_i       (cap_q),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res_ctrl),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // slot storage; one access per cycle so no same-entry overlap
  deq_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // result register; the controller holds while a stalled result waits in it
  deq_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_ctrl),
    .out_free_o  (out_free),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign status_o  = res_out.status;
  assign element_o = res_out.element;
  assign last_o    = res_out.last;

  // only defined status codes leave the block
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_DISP_EMPTY))
    else $error("undefined status code on output");

  // every result other than a display element closes its item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DISP_ELEM)) |-> last_o)
    else $error("single result without last mark");

  // refusals and empty reports carry no element
  a_zero_elem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL || status_o == ST_FRONT_REF ||
                     status_o == ST_EMPTY || status_o == ST_DISP_EMPTY))
    |-> (element_o == '0))
    else $error("nonzero element on refusal or empty result");

  // a result entering a full stalled output register would be lost
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(element_o)))
    else $error("stalled result overwritten");

endmodule

[test/deq_result_checker.sv]
// ----------------------------------------------------------------------------
// deq_result_checker
// watches the item, result and capacity channels of the linear deque, keeps
// its own copy of the slots, indices and capacity, and compares every result
// ----------------------------------------------------------------------------
module deq_result_checker
  import deq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [CMD_W-1:0]     command_i,
  input  logic signed [DW-1:0] value_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [ST_W-1:0]      status_i,
  input  logic signed [DW-1:0] element_i,
  input  logic                 last_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CAP_W-1:0]     cfg_capacity_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  logic signed [DW-1:0] slot_mem [DEPTH];
  int                   head_idx  = 0;
  int                   tail_next = 0;
  logic [CAP_W-1:0]     cap_reg   = CAP_RESET;
  res_t                 queued_results [$];
  res_t                 want;
  int                   fails     = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic push_result(input logic [ST_W-1:0] st, input logic signed [DW-1:0] el,
                             input logic lst);
    queued_results.push_back('{status: st, element: el, last: lst});
  endtask

  task automatic report_mismatch(input string field, input logic signed [DW-1:0] exp_v,
                                 input logic signed [DW-1:0] act_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    fails++;
  endtask

  // expected results of one accepted command, state updated in place
  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic signed [DW-1:0] val);
    int eff_cap;
    bit is_empty;
    eff_cap  = (cap_reg == '0) ? 1 : (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
    is_empty = head_idx >= tail_next;
    case (cmd)
      CMD_INS_REAR: begin
        if (tail_next >= eff_cap) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          slot_mem[tail_next] = val;
          tail_next++;
          push_result(ST_DONE, '0, 1'b1);
        end
      end
      CMD_INS_FRONT: begin
        if (head_idx == 0) begin
          push_result(ST_FRONT_REF, '0, 1'b1);
        end else begin
          head_idx--;
          slot_mem[head_idx] = val;
          push_result(ST_DONE, '0, 1'b1);
        end
      end
      CMD_DEL_FRONT, CMD_DEL_REAR: begin
        if (is_empty) begin
          head_idx  = 0;
          tail_next = 0;
          push_result(ST_EMPTY, '0, 1'b1);
        end else if (cmd == CMD_DEL_FRONT) begin
          push_result(ST_DONE, slot_mem[head_idx], 1'b1);
          head_idx++;
        end else begin
          tail_next--;
          push_result(ST_DONE, slot_mem[tail_next], 1'b1);
        end
      end
      CMD_DISPLAY: begin
        if (is_empty) begin
          push_result(ST_DISP_EMPTY, '0, 1'b1);
        end else begin
          for (int i = head_idx; i < tail_next; i++) begin
            push_result(ST_DISP_ELEM, slot_mem[i], (i + 1 == tail_next));
          end
        end
      end
      default: ;
    endcase
  endtask

  // results first: a result never belongs to the item taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (queued_results.size() == 0) begin
          $display("%0t: result with none expected, actual status %0d element %0d last %0d",
                   $time, status_i, element_i, last_i);
          fails++;
        end else begin
          want = queued_results.pop_front();
          if (status_i !== want.status)
            report_mismatch("status", DW'(want.status), DW'(status_i));
          if (element_i !== want.element) report_mismatch("element", want.element, element_i);
          if (last_i !== want.last)
            report_mismatch("last", DW'(want.last), DW'(last_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) cap_reg = cfg_capacity_i;
      if (in_valid_i && !in_stall_i) apply_command(command_i, value_i);
    end
    fail_count_o <= fails;
    pending_o    <= queued_results.size();
  end

endmodule

[test/tb_double_ended_queue_linear_top.sv]
// ----------------------------------------------------------------------------
// tb_double_ended_queue_linear_top
// drives commands and capacity settings into the linear deque, stalls the
// result side at random, and reports the verdict of the attached checker
// ----------------------------------------------------------------------------
module tb_double_ended_queue_linear_top;
  import deq_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  // quiet cycles before a capacity write, covers an ignored command in flight
  localparam int SETTLE_CYCLES = 8;

  // command codes the block does not decode
  localparam logic [CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI  = 3'd7;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     command     = '0;
  logic signed [DW-1:0] value       = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [ST_W-1:0]      status;
  logic signed [DW-1:0] element;
  logic                 last;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CAP_W-1:0]     cfg_cap     = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int snd_idle    = 0;   // percent of cycles the sender holds back
  int rcv_idle    = 0;   // percent of cycles the receiver stalls

  double_ended_queue_linear_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .element_o      (element),
    .last_o         (last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_capacity_i (cfg_cap)
  );

  deq_result_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .value_i        (value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .element_i      (element),
    .last_i         (last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_capacity_i (cfg_cap),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // 12 unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // random receiver stall, one draw per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle);
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // mostly random words, now and then one of the extremes
  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // present one item and hold it until the block takes it; valid stays high
  // so back-to-back items need no second assignment in the same step
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [DW-1:0] val);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // capacity writes happen only with the block idle
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_cap   <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one capacity setting, then a burst of weighted random commands;
  // rear_pct steers the burst toward filling or draining the queue
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_items, input int rear_pct);
    int r;
    logic [CMD_W-1:0] cmd;
    write_capacity(cap);
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < rear_pct) cmd = CMD_INS_REAR;
      else if (r < rear_pct + 12) cmd = CMD_INS_FRONT;
      else if (r < rear_pct + 20) cmd = CMD_DISPLAY;
      else if (r < rear_pct + 23) cmd = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
      else cmd = $urandom_range(0, 1) ? CMD_DEL_FRONT : CMD_DEL_REAR;
      send_item(cmd, pick_value());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver mostly stalled
    snd_idle = 11;
    rcv_idle <= 82;

    // directed walk with room for two elements
    write_capacity(7'd2);
    send_item(CMD_DEL_FRONT, 32'h1111_1111);   // delete on empty resets
    send_item(CMD_DEL_REAR, 32'h2222_2222);
    send_item(CMD_DISPLAY, 32'h3333_3333);     // display with nothing held
    send_item(CMD_INS_FRONT, 32'h1234_5678);   // front index zero, refused
    send_item(CMD_INS_REAR, 32'h7fff_ffff);
    send_item(CMD_INS_REAR, 32'h8000_0000);
    send_item(CMD_INS_REAR, 32'h0000_0000);    // capacity reached
    send_item(CMD_DISPLAY, 32'h0000_0000);
    send_item(CMD_DEL_FRONT, 32'h0);
    send_item(CMD_INS_FRONT, 32'hffff_ffff);   // front index now above zero
    send_item(CMD_INS_FRONT, 32'h0000_0001);
    send_item(CMD_DEL_REAR, 32'h0);
    send_item(CMD_RSVD_LO, 32'hffff_ffff);     // undecoded codes do nothing
    send_item(CMD_RSVD_MID, 32'h0);
    send_item(CMD_RSVD_HI, 32'h5555_5555);
    send_item(CMD_DISPLAY, 32'h0);
    send_item(CMD_DEL_REAR, 32'h0);
    send_item(CMD_DEL_FRONT, 32'h0);
    send_item(CMD_INS_REAR, 32'ha5a5_a5a5);
    send_item(CMD_DEL_FRONT, 32'h0);
    send_item(CMD_DISPLAY, 32'h0);             // empty with both indices at one
    send_item(CMD_INS_FRONT, 32'h5a5a_5a5a);
    send_item(CMD_DEL_FRONT, 32'h0);
    send_item(CMD_DEL_REAR, 32'h0);

    // above the slot count acts as full depth, then zero acts as one with
    // the held elements kept, then fill to the top and display it all
    run_phase(7'd127, 35, 75);
    run_phase(7'd0, 20, 40);
    run_phase(7'd64, 50, 75);

    // sender mostly idle, receiver mostly ready
    wait_drained();
    snd_idle = 82;
    rcv_idle <= 11;
    run_phase(7'd65, 30, 10);
    run_phase(7'd1, 25, 40);
    run_phase(CAP_W'($urandom_range(1, DEPTH)), 40, 45);

    // full rate both sides
    wait_drained();
    snd_idle = 0;
    rcv_idle <= 0;
    run_phase(7'd3, 30, 40);
    run_phase(7'd64, 30, 50);

    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
